>>> rtl/lgs_pkg.sv
`default_nettype none
package lgs_pkg;

  // opcodes of an input item
  typedef enum logic [1:0] {
    OP_WRITE = 2'd0,
    OP_READ  = 2'd1,
    OP_SWEEP = 2'd2,
    OP_INIT  = 2'd3
  } opcode_t;

  // configuration register indexes
  localparam logic [1:0] CFG_SIDE      = 2'd0;
  localparam logic [1:0] CFG_STEP_H    = 2'd1;
  localparam logic [1:0] CFG_TOLERANCE = 2'd2;

  localparam logic [7:0]  SIDE_RESET      = 8'd100;
  localparam logic [16:0] STEP_H_RESET    = 17'd662;
  localparam logic [30:0] TOLERANCE_RESET = 31'd7;
  localparam logic [23:0] SWEEP_MAX       = 24'hFFFFFF;

  typedef struct packed {
    opcode_t            opcode;
    logic [6:0]         row;
    logic [6:0]         col;
    logic signed [31:0] value;
  } in_t;

  typedef struct packed {
    logic signed [31:0] read_value;
    logic [31:0]        max_change;
    logic               converged;
    logic [23:0]        sweep_count;
  } out_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_RD_WAIT,
    ST_SW_READ,
    ST_SW_CALC,
    ST_SW_WRITE,
    ST_BD_SETUP,
    ST_BD_MUL,
    ST_BD_WRITE,
    ST_FINISH
  } state_t;

endpackage
`default_nettype wire

>>> rtl/lgs_ram.sv
`default_nettype none
module lgs_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16384
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // one write port, registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

>>> rtl/laplace_gauss_seidel_solver.sv
`default_nettype none
// Gauss-Seidel solver for the Laplace equation on a square grid of signed fixed-point cells
// held in one single-port-read block RAM. Each item is one opcode and gives one result item.
// The block takes no new item until the result of the current one is out. A sweep walks
// the interior cells one after another, and each cell has five reads through the single RAM
// read port, the quarter sum, then the write-back. A boundary init writes the 4*(side-1)
// edge cells, each corner twice. Each cell squares y with a shift-add multiplier that takes
// one bit per cycle.
module laplace_gauss_seidel_solver #(
  parameter int MAX_SIDE   = 128,
  parameter int VALUE_BITS = 32
) (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         in_valid,
  output logic              in_stall,
  input  wire lgs_pkg::in_t in_item,
  output logic              out_valid,
  input  wire logic         out_stall,
  output lgs_pkg::out_t     out_item,
  input  wire logic         cfg_valid,
  output logic              cfg_ready,
  input  wire logic [1:0]   cfg_index,
  input  wire logic [30:0]  cfg_data
);
  import lgs_pkg::*;

  localparam int IDX = $clog2(MAX_SIDE);
  localparam int NW  = $clog2(MAX_SIDE + 1);
  localparam int DEP = MAX_SIDE * MAX_SIDE;
  localparam int ADW = $clog2(DEP);
  localparam int YW  = IDX + 17;
  localparam int PRW = 2 * YW;
  localparam int CW  = $clog2(YW + 1);
  localparam int SUW = VALUE_BITS + 2;
  localparam int DW  = VALUE_BITS + 1;
  localparam logic signed [63:0] CELL_MAX = 64'sd2 ** (VALUE_BITS - 1) - 64'sd1;
  localparam logic signed [63:0] CELL_MIN = -CELL_MAX - 64'sd1;
  localparam logic signed [63:0] OUT_MAX  = 64'sd2147483647;
  localparam logic signed [63:0] OUT_MIN  = -64'sd2147483648;

  function automatic logic [ADW-1:0] addr_of(input logic [IDX-1:0] r,
                                             input logic [IDX-1:0] c);
    addr_of = ADW'(r) * ADW'(MAX_SIDE) + ADW'(c);
  endfunction

  function automatic logic [VALUE_BITS-1:0] sat_cell(input logic signed [63:0] v);
    logic signed [63:0] s;
    s = v;
    if (v > CELL_MAX) begin
      s = CELL_MAX;
    end else if (v < CELL_MIN) begin
      s = CELL_MIN;
    end
    sat_cell = s[VALUE_BITS-1:0];
  endfunction

  // configuration
  logic [7:0]  side;
  logic [16:0] step_h;
  logic [30:0] tolerance;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      side      <= SIDE_RESET;
      step_h    <= STEP_H_RESET;
      tolerance <= TOLERANCE_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_SIDE:      side      <= cfg_data[7:0];
        CFG_STEP_H:    step_h    <= cfg_data[16:0];
        CFG_TOLERANCE: tolerance <= cfg_data;
        default:       ;
      endcase
    end
  end

  // side in use, clamped
  logic [NW-1:0] n_live;
  logic [IDX-1:0] n_m1, n_m2;
  always_comb begin
    if (side < 8'd3) begin
      n_live = NW'(3);
    end else if (32'(side) > MAX_SIDE) begin
      n_live = NW'(MAX_SIDE);
    end else begin
      n_live = NW'(side);
    end
  end
  assign n_m1 = IDX'(n_live - NW'(1));
  assign n_m2 = IDX'(n_live - NW'(2));

  // state and datapath registers
  state_t state, state_next;
  logic [IDX-1:0] r_i, c_i;
  logic [2:0] phase;
  logic signed [SUW-1:0] sum;
  logic signed [VALUE_BITS-1:0] old_v, nv;
  logic [DW-1:0] worst;
  logic [32:0] last_change;
  logic [23:0] sweeps_done;
  logic [IDX-1:0] k_i;
  logic [1:0] side_sel;
  logic [IDX-1:0] br, bc;
  logic [YW-1:0] x_v;
  logic [PRW-1:0] prod, mcand;
  logic [YW-1:0] mplier;
  logic [CW-1:0] mcnt;
  logic signed [31:0] rd_val;
  logic rd_hit;

  logic in_acc;
  logic hit;
  logic [IDX-1:0] in_r, in_c;
  assign in_stall = (state != ST_IDLE);
  assign in_acc   = in_valid && !in_stall;
  assign hit      = (32'(in_item.row) < 32'(n_live)) && (32'(in_item.col) < 32'(n_live));
  assign in_r     = IDX'(in_item.row);
  assign in_c     = IDX'(in_item.col);

  // ram ports
  logic ram_we;
  logic [ADW-1:0] ram_waddr, ram_raddr;
  logic [VALUE_BITS-1:0] ram_wdata, ram_rdata;

  lgs_ram #(.WIDTH(VALUE_BITS), .DEPTH(DEP)) u_grid (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  // boundary value of the current edge cell
  logic [PRW:0] ysq_round;
  logic signed [63:0] phi;
  assign ysq_round = ({1'b0, prod} + (PRW+1)'(32768)) >> 16;
  assign phi = signed'(64'(ysq_round) << 2) - signed'(64'(x_v));

  // edge cell chosen by k and the edge selector
  logic [IDX-1:0] sel_r, sel_c;
  always_comb begin
    case (side_sel)
      2'd0:    begin sel_r = k_i;  sel_c = '0;   end
      2'd1:    begin sel_r = k_i;  sel_c = n_m1; end
      2'd2:    begin sel_r = '0;   sel_c = k_i;  end
      default: begin sel_r = n_m1; sel_c = k_i;  end
    endcase
  end

  // sweep difference
  logic signed [DW-1:0] diff;
  logic [DW-1:0] adiff;
  assign diff  = DW'(nv) - DW'(old_v);
  assign adiff = diff[DW-1] ? DW'(-diff) : DW'(diff);

  logic last_col, last_row;
  assign last_col = (c_i == n_m2);
  assign last_row = (r_i == n_m2);

  logic out_free;
  assign out_free = !out_valid || !out_stall;

  // next state and ram control
  always_comb begin
    state_next = state;
    ram_we     = 1'b0;
    ram_waddr  = addr_of(in_r, in_c);
    ram_wdata  = sat_cell(64'(in_item.value));
    ram_raddr  = addr_of(in_r, in_c);
    case (state)
      ST_IDLE: begin
        if (in_acc) begin
          case (in_item.opcode)
            OP_WRITE: begin
              ram_we     = hit;
              state_next = ST_FINISH;
            end
            OP_READ:  state_next = ST_RD_WAIT;
            OP_SWEEP: state_next = ST_SW_READ;
            default:  state_next = ST_BD_SETUP;
          endcase
        end
      end
      ST_RD_WAIT: state_next = ST_FINISH;
      ST_SW_READ: begin
        case (phase)
          3'd0:    ram_raddr = addr_of(r_i, c_i - IDX'(1));
          3'd1:    ram_raddr = addr_of(r_i, c_i + IDX'(1));
          3'd2:    ram_raddr = addr_of(r_i + IDX'(1), c_i);
          3'd3:    ram_raddr = addr_of(r_i - IDX'(1), c_i);
          default: ram_raddr = addr_of(r_i, c_i);
        endcase
        if (phase == 3'd5) begin
          state_next = ST_SW_CALC;
        end
      end
      ST_SW_CALC: state_next = ST_SW_WRITE;
      ST_SW_WRITE: begin
        ram_we     = 1'b1;
        ram_waddr  = addr_of(r_i, c_i);
        ram_wdata  = nv;
        state_next = (last_col && last_row) ? ST_FINISH : ST_SW_READ;
      end
      ST_BD_SETUP: state_next = ST_BD_MUL;
      ST_BD_MUL: begin
        if (mcnt == CW'(YW - 1)) begin
          state_next = ST_BD_WRITE;
        end
      end
      ST_BD_WRITE: begin
        ram_we     = 1'b1;
        ram_waddr  = addr_of(br, bc);
        ram_wdata  = sat_cell(phi);
        state_next = (side_sel == 2'd3 && k_i == n_m1) ? ST_FINISH : ST_BD_SETUP;
      end
      ST_FINISH: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (rst) begin
      last_change <= '0;
      sweeps_done <= '0;
      out_valid   <= 1'b0;
      rd_hit      <= 1'b0;
    end else begin
      if (out_valid && !out_stall && state != ST_FINISH) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          rd_hit   <= in_acc && (in_item.opcode == OP_READ) && hit;
          r_i      <= IDX'(1);
          c_i      <= IDX'(1);
          phase    <= '0;
          worst    <= '0;
          k_i      <= '0;
          side_sel <= '0;
        end
        ST_RD_WAIT: begin
          if (signed'(64'(signed'(ram_rdata))) > OUT_MAX) begin
            rd_val <= 32'(OUT_MAX);
          end else if (signed'(64'(signed'(ram_rdata))) < OUT_MIN) begin
            rd_val <= 32'(OUT_MIN);
          end else begin
            rd_val <= 32'(signed'(64'(signed'(ram_rdata))));
          end
        end
        ST_SW_READ: begin
          // neighbor data arrives in the cycle after its address
          if (phase == 3'd0) begin
            sum <= '0;
          end else if (phase == 3'd5) begin
            old_v <= ram_rdata;
          end else begin
            sum <= sum + SUW'(signed'(ram_rdata));
          end
          phase <= (phase == 3'd5) ? 3'd0 : phase + 3'd1;
        end
        ST_SW_CALC: begin
          nv <= VALUE_BITS'((sum + SUW'(2)) >>> 2);
        end
        ST_SW_WRITE: begin
          if (adiff > worst) begin
            worst <= adiff;
          end
          if (last_col) begin
            c_i <= IDX'(1);
            r_i <= r_i + IDX'(1);
          end else begin
            c_i <= c_i + IDX'(1);
          end
          if (last_col && last_row) begin
            last_change <= 33'(64'((adiff > worst) ? adiff : worst));
            if (sweeps_done != SWEEP_MAX) begin
              sweeps_done <= sweeps_done + 24'd1;
            end
          end
        end
        ST_BD_SETUP: begin
          br     <= sel_r;
          bc     <= sel_c;
          x_v    <= YW'(sel_r) * YW'(step_h);
          mplier <= YW'(sel_c) * YW'(step_h);
          mcand  <= PRW'(YW'(sel_c) * YW'(step_h));
          prod   <= '0;
          mcnt   <= '0;
        end
        ST_BD_MUL: begin
          // shift-add square, one multiplier bit per cycle
          if (mplier[0]) begin
            prod <= prod + mcand;
          end
          mcand  <= mcand << 1;
          mplier <= mplier >> 1;
          mcnt   <= mcnt + CW'(1);
        end
        ST_BD_WRITE: begin
          side_sel <= side_sel + 2'd1;
          if (side_sel == 2'd3) begin
            k_i <= k_i + IDX'(1);
          end
        end
        ST_FINISH: begin
          if (out_free) begin
            out_valid            <= 1'b1;
            out_item.read_value  <= rd_hit ? rd_val : 32'sd0;
            out_item.max_change  <= last_change[32] ? 32'hFFFFFFFF : last_change[31:0];
            out_item.converged   <= (sweeps_done != 24'd0) &&
                                    (last_change <= 33'(tolerance));
            out_item.sweep_count <= sweeps_done;
          end
        end
        default: ;
      endcase
    end
  end

endmodule
`default_nettype wire
